[hw/rtl/sbc_pkg.sv]
// ----------------------------------------------------------------------------
// sbc_pkg: shared types and constants of the sorted read bin counter
// Field widths, register indexes, item and status codes, and the queue entry
// that travels from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package sbc_pkg;

	// Default coordinate width; positions are clipped to this many bits.
	localparam int COORD_BITS_DEF = 32;

	// Fixed field widths.
	localparam int POS_W    = 32;
	localparam int CHROM_W  = 8;
	localparam int SIZE_W   = 24;
	localparam int LEN_W    = 24;
	localparam int PSEUDO_W = 16;
	localparam int SCORE_W  = 32;
	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] CFG_BIN_SIZE     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PSEUDO_COUNT = 1'b1;

	localparam logic [SIZE_W-1:0]   BIN_SIZE_RST = 24'd50;
	localparam logic [PSEUDO_W-1:0] PSEUDO_RST   = 16'd0;

	// Input item kinds.
	localparam logic [FUNC_W-1:0] FUNC_READ     = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REQUIRED = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FLUSH    = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_NOP      = 2'd3;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_BIN       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_SIZE_ERR  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ORDER_ERR = 2'd2;

	// Depth of the queue between front end and back end.
	localparam int Q_DEPTH = 2;

	// Request class as decided by the front end.
	typedef enum logic [1:0] {
		KIND_READ,
		KIND_REQUIRED,
		KIND_FLUSH,
		KIND_BAD_LEN
	} sbc_kind_t;

	// Front end sequencer states.
	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} sbc_fstate_t;

	// One classified request, ready for the back end.
	typedef struct packed {
		sbc_kind_t          kind;
		logic [CHROM_W-1:0] chrom;
		logic [POS_W-1:0]   pos;       // clipped position
		logic [POS_W-1:0]   bin_base;  // position rounded down to its bin
	} sbc_entry_t;

endpackage

`default_nettype wire

[hw/rtl/sbc_front.sv]
// ----------------------------------------------------------------------------
// sbc_front: request intake, classification and bin alignment
// Takes one request, checks the required length, and finds the start of its
// bin with a restoring remainder unit that handles one position bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_front #(
	parameter int COORD_BITS = sbc_pkg::COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [sbc_pkg::FUNC_W-1:0]  in_func,
	input  logic [sbc_pkg::CHROM_W-1:0] in_chrom,
	input  logic [sbc_pkg::POS_W-1:0]   in_pos,
	input  logic [sbc_pkg::LEN_W-1:0]   in_len,
	input  logic [sbc_pkg::SIZE_W-1:0]  size_eff,
	output logic                        push,
	input  logic                        full,
	output sbc_pkg::sbc_entry_t         push_entry
);
	import sbc_pkg::*;

	localparam int PW    = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;
	localparam int CNT_W = $clog2(PW);

	sbc_fstate_t        state_q, state_d;
	sbc_kind_t          kind_q, in_kind;
	logic [CHROM_W-1:0] chrom_q;
	logic [PW-1:0]      pos_q;
	logic [SIZE_W-1:0]  rem_q, rem_step;
	logic [CNT_W-1:0]   cnt_q;
	logic [SIZE_W:0]    trial, diff;

	// Classification of the offered request.
	always_comb begin
		unique case (in_func)
			FUNC_READ:     in_kind = KIND_READ;
			FUNC_REQUIRED: in_kind = (in_len != size_eff) ? KIND_BAD_LEN : KIND_REQUIRED;
			FUNC_FLUSH:    in_kind = KIND_FLUSH;
			default:       in_kind = KIND_READ;
		endcase
	end

	// One remainder step: bring in the next position bit, subtract if it fits.
	always_comb begin
		trial    = {rem_q, pos_q[cnt_q]};
		diff     = trial - {1'b0, size_eff};
		rem_step = (trial >= {1'b0, size_eff}) ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		push     = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					priority if (in_func == FUNC_NOP) begin
						state_d = F_IDLE;
					end else if (in_kind == KIND_FLUSH || in_kind == KIND_BAD_LEN) begin
						state_d = F_PUSH;
					end else begin
						state_d = F_DIV;
					end
				end
			end
			F_DIV: begin
				if (cnt_q == '0) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				push = 1'b1;
				if (!full) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			kind_q  <= in_kind;
			chrom_q <= in_chrom;
			pos_q   <= in_pos[PW-1:0];
			rem_q   <= '0;
			cnt_q   <= CNT_W'(PW - 1);
		end else if (state_q == F_DIV) begin
			rem_q <= rem_step;
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// The remainder never exceeds the position, so it fits in PW bits.
	always_comb begin
		push_entry.kind     = kind_q;
		push_entry.chrom    = chrom_q;
		push_entry.pos      = POS_W'(pos_q);
		push_entry.bin_base = POS_W'(pos_q - PW'(rem_q));
	end

endmodule

`default_nettype wire

[hw/rtl/sbc_fifo.sv]
// ----------------------------------------------------------------------------
// sbc_fifo: short queue of classified requests
// Decouples the alignment unit from the bin state update.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sbc_pkg::sbc_entry_t wr_entry,
	output logic                full,
	input  logic                pop,
	output logic                rd_valid,
	output sbc_pkg::sbc_entry_t rd_entry
);
	import sbc_pkg::*;

	localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	sbc_entry_t       mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full     = (cnt_q == CNT_W'(Q_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_entry = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/sbc_back.sv]
// ----------------------------------------------------------------------------
// sbc_back: open bin state and result register
// Applies one classified request a cycle to the open bin, unless a held result
// stalls it, and loads closed bins and error reports into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_back #(
	parameter int COORD_BITS = sbc_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  sbc_pkg::sbc_entry_t          q_entry,
	output logic                         q_pop,
	input  logic [sbc_pkg::SIZE_W-1:0]   size_eff,
	input  logic [sbc_pkg::PSEUDO_W-1:0] pseudo,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [sbc_pkg::CHROM_W-1:0]  out_chrom,
	output logic [sbc_pkg::POS_W-1:0]    bin_start,
	output logic [sbc_pkg::POS_W-1:0]    bin_end,
	output logic [sbc_pkg::SCORE_W-1:0]  score,
	output logic [sbc_pkg::STATUS_W-1:0] status
);
	import sbc_pkg::*;

	localparam int PW = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;
	localparam int EW = ((PW > SIZE_W) ? PW : SIZE_W) + 1;

	// Open bin state.
	logic               open_q, open_d;
	logic [CHROM_W-1:0] chrom_q, chrom_d;
	logic [PW-1:0]      start_q, start_d;
	logic [SCORE_W-1:0] count_q, count_d;
	logic               req_q, req_d;

	// Output register.
	logic                out_valid_q;
	logic [CHROM_W-1:0]  o_chrom_q, e_chrom;
	logic [POS_W-1:0]    o_start_q, e_start;
	logic [POS_W-1:0]    o_end_q, e_end;
	logic [SCORE_W-1:0]  o_score_q, e_score;
	logic [STATUS_W-1:0] o_status_q, e_status;

	logic             take, emit, qualifies, same_bin_chrom;
	logic [PW-1:0]    e_pos, e_base, end_sat;
	logic [EW-1:0]    end_sum;
	logic [SCORE_W:0] score_sum;
	logic [SCORE_W-1:0] score_sat;

	assign take  = q_valid && (!out_valid_q || out_ready);
	assign q_pop = take;

	assign e_pos  = q_entry.pos[PW-1:0];
	assign e_base = q_entry.bin_base[PW-1:0];

	// Closing figures of the open bin, both saturating.
	assign end_sum   = EW'(start_q) + EW'(size_eff);
	assign end_sat   = (end_sum > EW'({PW{1'b1}})) ? {PW{1'b1}} : end_sum[PW-1:0];
	assign score_sum = {1'b0, count_q} + (SCORE_W + 1)'(pseudo);
	assign score_sat = score_sum[SCORE_W] ? {SCORE_W{1'b1}} : score_sum[SCORE_W-1:0];

	assign qualifies      = open_q && (count_q != '0 || req_q);
	assign same_bin_chrom = open_q && (q_entry.chrom == chrom_q);

	always_comb begin
		open_d   = open_q;
		chrom_d  = chrom_q;
		start_d  = start_q;
		count_d  = count_q;
		req_d    = req_q;
		emit     = 1'b0;
		e_chrom  = chrom_q;
		e_start  = POS_W'(start_q);
		e_end    = POS_W'(end_sat);
		e_score  = score_sat;
		e_status = STATUS_BIN;
		if (take) begin
			priority if (q_entry.kind == KIND_FLUSH) begin
				emit    = qualifies;
				open_d  = 1'b0;
				chrom_d = '0;
				start_d = '0;
				count_d = '0;
				req_d   = 1'b0;
			end else if (q_entry.chrom < chrom_q) begin
				emit     = 1'b1;
				e_chrom  = q_entry.chrom;
				e_start  = POS_W'(e_pos);
				e_end    = '0;
				e_score  = '0;
				e_status = STATUS_ORDER_ERR;
			end else if (q_entry.kind == KIND_BAD_LEN) begin
				emit     = 1'b1;
				e_chrom  = q_entry.chrom;
				e_start  = POS_W'(e_pos);
				e_end    = '0;
				e_score  = '0;
				e_status = STATUS_SIZE_ERR;
			end else if (same_bin_chrom && e_base < start_q) begin
				// Falls in an earlier bin: consumed without effect.
			end else if (same_bin_chrom && e_base == start_q) begin
				if (q_entry.kind == KIND_READ) begin
					count_d = (count_q != {SCORE_W{1'b1}}) ? count_q + SCORE_W'(1) : count_q;
				end else begin
					req_d = 1'b1;
				end
			end else begin
				emit    = qualifies;
				open_d  = 1'b1;
				chrom_d = q_entry.chrom;
				start_d = e_base;
				count_d = (q_entry.kind == KIND_READ) ? SCORE_W'(1) : '0;
				req_d   = (q_entry.kind == KIND_REQUIRED);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q      <= 1'b0;
			chrom_q     <= '0;
			start_q     <= '0;
			count_q     <= '0;
			req_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			open_q  <= open_d;
			chrom_q <= chrom_d;
			start_q <= start_d;
			count_q <= count_d;
			req_q   <= req_d;
			if (take && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			o_chrom_q  <= e_chrom;
			o_start_q  <= e_start;
			o_end_q    <= e_end;
			o_score_q  <= e_score;
			o_status_q <= e_status;
		end
	end

	assign out_valid = out_valid_q;
	assign out_chrom = o_chrom_q;
	assign bin_start = o_start_q;
	assign bin_end   = o_end_q;
	assign score     = o_score_q;
	assign status    = o_status_q;

endmodule

`default_nettype wire

[hw/rtl/sorted_read_bin_counter.sv]
// ----------------------------------------------------------------------------
// sorted_read_bin_counter: fixed-width read binning over a sorted stream
// Counts read starts into zero-aligned bins of a programmable width and
// emits each closed bin that holds reads or was marked required.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake           Contents
// s_*       in         s_tvalid/s_tready   read, required bin or flush request
// m_*       out        m_tvalid/m_tready   closed bin or error report
// cfg_*     in         cfg_we              bin_size (index 0), pseudo_count (index 1)
//
// A read or required request holds the front end while the remainder unit rounds
// the position down to its bin one bit a cycle. Flush and length-error requests
// go straight to the push step, and the unused request kind is dropped at intake.
// The back end applies one queued request a cycle unless a result waits on
// m_tready; a full two-entry queue holds the front end in its push step.
// Reset is asynchronous and needs no clearing pass; the block is ready at once.
//
`default_nettype none

module sorted_read_bin_counter #(
	parameter int COORD_BITS = sbc_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Request stream.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [63:0]                    s_tdata,   // chrom_id, position, region_len
	input  logic [sbc_pkg::FUNC_W-1:0]     s_tuser,   // func
	// Result stream.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [103:0]                   m_tdata,   // out_chrom, bin_start, bin_end, score
	output logic [sbc_pkg::STATUS_W-1:0]   m_tuser,   // status
	// Configuration writes.
	input  logic                           cfg_we,
	input  logic [sbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sbc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sbc_pkg::*;

	// Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
	logic [SIZE_W-1:0]   bin_size_q;
	logic [PSEUDO_W-1:0] pseudo_q;
	logic [SIZE_W-1:0]   size_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_size_q <= BIN_SIZE_RST;
			pseudo_q   <= PSEUDO_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BIN_SIZE:     bin_size_q <= cfg_data[SIZE_W-1:0];
				CFG_PSEUDO_COUNT: pseudo_q   <= cfg_data[PSEUDO_W-1:0];
				default:          ;
			endcase
		end
	end

	// A bin size of zero behaves as a size of one.
	assign size_eff = (bin_size_q == '0) ? SIZE_W'(1) : bin_size_q;

	// Front end: intake, length check and bin alignment.
	logic       q_push, q_full, q_pop, q_valid;
	sbc_entry_t q_wr_entry, q_rd_entry;

	sbc_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_func    (s_tuser),
		.in_chrom   (s_tdata[7:0]),
		.in_pos     (s_tdata[39:8]),
		.in_len     (s_tdata[63:40]),
		.size_eff   (size_eff),
		.push       (q_push),
		.full       (q_full),
		.push_entry (q_wr_entry)
	);

	sbc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr_entry),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_entry (q_rd_entry)
	);

	// Back end: bin state and the output register.
	logic [CHROM_W-1:0]  out_chrom;
	logic [POS_W-1:0]    bin_start, bin_end;
	logic [SCORE_W-1:0]  score;

	sbc_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_entry   (q_rd_entry),
		.q_pop     (q_pop),
		.size_eff  (size_eff),
		.pseudo    (pseudo_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_chrom (out_chrom),
		.bin_start (bin_start),
		.bin_end   (bin_end),
		.score     (score),
		.status    (m_tuser)
	);

	assign m_tdata = {score, bin_end, bin_start, out_chrom};

endmodule

`default_nettype wire

[hw/rtl/sbc_checker.sv]
// ----------------------------------------------------------------------------
// sbc_checker: port-level checks of the sorted read bin counter
// Watches both streams and flags results or handshakes that cannot occur.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic [sbc_pkg::FUNC_W-1:0]   s_tuser,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [103:0]                 m_tdata,
	input logic [sbc_pkg::STATUS_W-1:0] m_tuser
);
	import sbc_pkg::*;

	// A stalled result holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Error reports carry a zero bin end and score.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != STATUS_BIN |-> m_tdata[103:40] == '0)
		else $error("error report with nonzero end or score");

	// An emitted bin never ends before it starts.
	a_bin_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STATUS_BIN |-> m_tdata[71:40] >= m_tdata[39:8])
		else $error("bin end below bin start");

	// A request that does work keeps the intake busy in the next cycle.
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != FUNC_NOP |=> !s_tready)
		else $error("intake ready right after a request");

endmodule

bind sorted_read_bin_counter sbc_checker u_sbc_checker (.*);

`default_nettype wire
